// File: hdl/sbt_pkg.sv
// Shared types and constants of the sorted byte table.
// No dependencies; every other file of the block uses it.
package sbt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VALUE_W = 8;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               do_ins;
    logic               do_del;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: hdl/sbt_in_if.sv
// Request channel of the sorted byte table: command and byte value.
// Depends on sbt_pkg.
interface sbt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [sbt_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: hdl/sbt_out_if.sv
// Result channel of the sorted byte table: status, entry count, empty flag.
// Depends on sbt_pkg.
interface sbt_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [sbt_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic                             is_empty;

  modport source (output valid, output status, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  output ready);
endinterface

// File: hdl/sbt_cell.sv
// One position of the sorted table: holds a byte, compares it with the
// broadcast value and shifts in from a neighbor. Depends on sbt_pkg.
module sbt_cell (
  input  logic                        clk,
  input  sbt_pkg::cell_ctl_t          ctl,
  input  logic                        occ,
  input  logic [sbt_pkg::VALUE_W-1:0] left_val,
  input  logic                        left_gt,
  input  logic [sbt_pkg::VALUE_W-1:0] right_val,
  output logic [sbt_pkg::VALUE_W-1:0] val,
  output logic                        gt,
  output logic                        eq
);

  logic [sbt_pkg::VALUE_W-1:0] val_r;
  logic [sbt_pkg::VALUE_W-1:0] val_nxt;
  logic                        lt;

  always_comb begin
    gt = occ && (ctl.value > val_r);
    lt = occ && (ctl.value < val_r) ? 1'b0 : 1'b0;
    lt = occ && (val_r < ctl.value);
    eq = occ && (val_r == ctl.value);
    val_nxt = val_r;
    if (ctl.do_ins && !gt) begin
      // first cell not below the value takes it, the rest move up
      val_nxt = left_gt ? ctl.value : left_val;
    end else if (ctl.do_del && !lt) begin
      // from the first match on, close the gap
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: hdl/sorted_byte_table_insert_delete_unit.sv
// Sorted byte table: a row of compare-and-shift cells and the entry count.
// Depends on sbt_pkg, sbt_in_if, sbt_out_if and sbt_cell.
//
// Usage:
//   in_chan  (sink)   carries a request: cmd (insert / delete) and a byte value.
//   out_chan (source) carries one result per request: status, entry_count
//                     after the step and is_empty.
//   A request is taken when valid and ready are both high. Every cell compares
//   its byte with the request value in the same cycle and shifts in from its
//   neighbor, so the whole insert or delete finishes at the accepting edge.
//   The result is registered: it is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while out_chan does not stall, since the cell
//   row and the count update are combinational; the result register frees in the
//   cycle it is taken, so a request is accepted while the previous result is being read.
//   Stall: while a result waits and out_chan.ready is low, in_chan.ready is low.
//   Reset (rst_n low, synchronous): the count goes to zero and no result is
//   pending. Table contents are not cleared; positions beyond the count are
//   never used.
module sorted_byte_table_insert_delete_unit (
  input  logic      clk,
  input  logic      rst_n,
  sbt_in_if.sink    in_chan,
  sbt_out_if.source out_chan
);

  localparam int CAP = sbt_pkg::CAPACITY;
  localparam int CW  = sbt_pkg::CNT_W;
  localparam int VW  = sbt_pkg::VALUE_W;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic [1:0]          status_r;
  logic [1:0]          status_nxt;
  logic [sbt_pkg::ENTRY_COUNT_W-1:0] entry_count_r;
  logic                is_empty_r;

  logic                accept;
  logic                is_del;
  logic                full;
  logic                found;
  sbt_pkg::cell_ctl_t  ctl;

  logic [VW-1:0]       cell_val [CAP];
  logic [CAP-1:0]      cell_gt;
  logic [CAP-1:0]      cell_eq;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept = in_chan.valid && in_chan.ready;
  assign is_del = (in_chan.cmd == sbt_pkg::CMD_DELETE);
  assign full   = (count_r == CW'(CAP));
  assign found  = |cell_eq;

  always_comb begin
    ctl.value  = in_chan.value;
    ctl.do_ins = accept && !is_del && !full;
    ctl.do_del = accept && is_del && found;
  end

  genvar i;
  generate
    for (i = 0; i < CAP; i++) begin : g_cell
      logic [VW-1:0] left_val;
      logic          left_gt;
      logic [VW-1:0] right_val;

      if (i == 0) begin : g_first
        assign left_val = in_chan.value;
        assign left_gt  = 1'b1;
      end else begin : g_mid
        assign left_val = cell_val[i-1];
        assign left_gt  = cell_gt[i-1];
      end

      if (i == CAP - 1) begin : g_last
        assign right_val = cell_val[i];
      end else begin : g_inner
        assign right_val = cell_val[i+1];
      end

      sbt_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (CW'(i) < count_r),
        .left_val  (left_val),
        .left_gt   (left_gt),
        .right_val (right_val),
        .val       (cell_val[i]),
        .gt        (cell_gt[i]),
        .eq        (cell_eq[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = sbt_pkg::ST_INSERTED;
    if (is_del) begin
      if (found) begin
        count_nxt  = count_r - CW'(1);
        status_nxt = sbt_pkg::ST_DELETED;
      end else begin
        status_nxt = sbt_pkg::ST_NOT_FOUND;
      end
    end else begin
      if (full) begin
        status_nxt = sbt_pkg::ST_FULL;
      end else begin
        count_nxt  = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      entry_count_r <= sbt_pkg::ENTRY_COUNT_W'(count_nxt);
      is_empty_r    <= (count_nxt == '0);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_count = entry_count_r;
  assign out_chan.is_empty    = is_empty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (count_r == $past(count_r)))
    else $error("entry count changed without a request");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == sbt_pkg::ST_FULL) |-> (count_r == CW'(CAP)))
    else $error("full status reported below capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (is_empty_r == (count_r == '0)))
    else $error("result missing or empty flag wrong after a request");
`endif

endmodule

// File: test/sbt_table_tracker.sv
`timescale 1ns / 1ps
// Checker for the sorted byte table: tracks the table contents from accepted
// requests, predicts each result and compares it with the result channel.
// Depends on sbt_pkg, sbt_in_if and sbt_out_if.
module sbt_table_tracker (
  input  logic clk,
  input  logic rst_n,
  sbt_in_if    in_mon,
  sbt_out_if   out_mon,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    sbt_pkg::status_t                  status;
    logic [sbt_pkg::ENTRY_COUNT_W-1:0] entry_count;
    logic                              is_empty;
  } table_result_t;

  logic [sbt_pkg::VALUE_W-1:0] table_bytes [sbt_pkg::CAPACITY];
  int                          held;
  table_result_t               expected_results [$];

  // Apply one request to the tracked table and return the result it should give.
  function automatic table_result_t apply_request(sbt_pkg::cmd_t op,
                                                  logic [sbt_pkg::VALUE_W-1:0] v);
    int            pos;
    table_result_t r;
    pos = 0;
    if (op == sbt_pkg::CMD_INSERT) begin
      if (held >= sbt_pkg::CAPACITY) begin
        r.status = sbt_pkg::ST_FULL;
      end else begin
        // stop in front of the first entry that is not smaller
        while (pos < held && v > table_bytes[pos]) pos++;
        for (int k = held; k > pos; k--) table_bytes[k] = table_bytes[k - 1];
        table_bytes[pos] = v;
        held++;
        r.status = sbt_pkg::ST_INSERTED;
      end
    end else begin
      while (pos < held && table_bytes[pos] != v) pos++;
      if (pos >= held) begin
        r.status = sbt_pkg::ST_NOT_FOUND;
      end else begin
        // close the gap
        for (int k = pos; k + 1 < held; k++) table_bytes[k] = table_bytes[k + 1];
        held--;
        r.status = sbt_pkg::ST_DELETED;
      end
    end
    r.entry_count = sbt_pkg::ENTRY_COUNT_W'(held);
    r.is_empty    = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      held       = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      // the result leaving now belongs to an earlier request: compare before predicting
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result status with no request pending", -1, out_mon.status);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", want.status, out_mon.status);
          if (out_mon.entry_count !== want.entry_count)
            report_mismatch("entry_count", want.entry_count, out_mon.entry_count);
          if (out_mon.is_empty !== want.is_empty)
            report_mismatch("is_empty", want.is_empty, out_mon.is_empty);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_request(sbt_pkg::cmd_t'(in_mon.cmd),
                                                 in_mon.value));
    end
    awaiting = expected_results.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the sorted byte table testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on sbt_pkg, the channel
// interfaces, the unit under test and sbt_table_tracker.
module testbench;

  localparam int RANDOM_PER_PHASE = 416;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatches;
  int   awaiting;

  sbt_in_if  in_chan ();
  sbt_out_if out_chan ();

  sorted_byte_table_insert_delete_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sbt_table_tracker table_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure; hold ready low during reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the request until it is taken; idle beforehand at the sender's rate.
  task automatic send_request(input sbt_pkg::cmd_t op,
                              input logic [sbt_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd   <= op;
    in_chan.value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  initial begin
    logic [sbt_pkg::VALUE_W-1:0] pool [8];
    int                          insert_bias;
    sbt_pkg::cmd_t               op;
    logic [sbt_pkg::VALUE_W-1:0] v;

    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.cmd    = sbt_pkg::CMD_INSERT;
    in_chan.value  = '0;
    send_idle_pct  = 14;
    recv_idle_pct  = 46;
    insert_bias    = 50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: delete on empty, extremes, duplicates, fill past full, then deletes and an insert.
    send_request(sbt_pkg::CMD_DELETE, 8'h07);
    send_request(sbt_pkg::CMD_INSERT, 8'h00);
    send_request(sbt_pkg::CMD_INSERT, 8'hFF);
    send_request(sbt_pkg::CMD_INSERT, 8'h80);
    send_request(sbt_pkg::CMD_INSERT, 8'h80);
    send_request(sbt_pkg::CMD_INSERT, 8'h00);
    for (int i = 0; i < 11; i++)
      send_request(sbt_pkg::CMD_INSERT, sbt_pkg::VALUE_W'(i * 23 + 5));
    send_request(sbt_pkg::CMD_INSERT, 8'h42);
    send_request(sbt_pkg::CMD_DELETE, 8'h01);
    send_request(sbt_pkg::CMD_DELETE, 8'h00);
    send_request(sbt_pkg::CMD_DELETE, 8'hFF);
    send_request(sbt_pkg::CMD_DELETE, 8'h80);
    send_request(sbt_pkg::CMD_INSERT, 8'h55);

    // Random: drift between filling and draining so both ends of the table are hit.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % 40 == 0) begin
          insert_bias = $urandom_range(1) ? 70 : 30;
          foreach (pool[j]) pool[j] = sbt_pkg::VALUE_W'($urandom_range(255));
          pool[0] = $urandom_range(1) ? 8'h00 : 8'hFF;
        end
        op = ($urandom_range(99) < insert_bias) ? sbt_pkg::CMD_INSERT : sbt_pkg::CMD_DELETE;
        v  = ($urandom_range(3) == 0) ? sbt_pkg::VALUE_W'($urandom_range(255))
                                      : pool[$urandom_range(7)];
        send_request(op, v);
      end
    end
    in_chan.valid <= 1'b0;

    // Drain: sample on the falling edge, away from the checker's updates.
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
